@@ rtl/core/cqdv_pkg.sv @@
// Package for the circular queue with remove-by-value.
// Holds the request and response structs, operation and status codes and the cell control struct.
// No dependencies.
`default_nettype none

package cqdv_pkg;

	// Operation codes carried in the request func field.
	localparam logic FUNC_ENQUEUE = 1'b0;
	localparam logic FUNC_REMOVE  = 1'b1;

	// Status codes returned in the response.
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic               func;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] occupancy;
	} rsp_t;

	// Control handed to every storage cell.
	typedef struct packed {
		logic cmp;    // compare the incoming word against the held entry
		logic shift;  // a remove is executing: matched cell and newer ones pull from newer neighbor
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/cqdv_cell.sv @@
// One storage cell of the queue: holds one entry and its registered match flag.
// Depends on cqdv_pkg for the cell control struct.
`default_nettype none

module cqdv_cell
	import cqdv_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input  wire logic                 clk,
	input  wire cell_ctl_t            ctl,
	input  wire logic [WORD_BITS-1:0] cmp_word,
	input  wire logic                 load,
	input  wire logic [WORD_BITS-1:0] load_word,
	input  wire logic                 occupied,
	input  wire logic [WORD_BITS-1:0] newer_word,
	input  wire logic                 seen_in,
	output logic                      seen_out,
	output logic [WORD_BITS-1:0]      word
);

	logic [WORD_BITS-1:0] entry_q;
	logic                 match_s1;

	// A match here or in any older cell means this cell closes the gap.
	assign seen_out = seen_in | match_s1;
	assign word     = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			match_s1 <= occupied & (entry_q == cmp_word);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_word;
		end else if (ctl.shift && seen_out) begin
			entry_q <= newer_word;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/circular_queue_delete_by_value.sv @@
// Flow: an accepted request is held in the request registers; it executes once the output register
// is free or being emptied, and its response is registered in the output register at execution.
// The cells compare on acceptance, and a remove shifts the cells when it executes. A new request is
// not taken until the previous one has executed; the input stalls while a request waits to execute.
// Reset: arst_n clears the occupancy count and the control flags; stored words are not cleared.
`default_nettype none

module circular_queue_delete_by_value
	import cqdv_pkg::*;
#(
	parameter int DEPTH     = 256,
	parameter int WORD_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	// The queue is held in logical order: cell 0 holds the oldest entry and
	// cells below the count are occupied. Removing an entry makes every newer
	// cell pull the word from its newer neighbor, which keeps the order and
	// matches the circular buffer's behavior as seen at the ports.
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]        count_q;
	logic                 busy_q;
	logic                 func_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 accept;
	logic                 exec;
	logic [WORD_BITS-1:0] word_in;
	logic                 full;
	logic                 enq_ok;
	logic                 found;
	cell_ctl_t            ctl;

	logic [WORD_BITS-1:0] cell_word [DEPTH];
	logic                 seen [DEPTH+1];

	// The incoming value is sign-extended or truncated to the stored word width.
	assign word_in = WORD_BITS'(req.value);

	// A request is taken only when nothing is executing.
	assign req_stall = busy_q;
	assign accept    = req_valid & ~busy_q;

	// Execution waits until the output register is free or is being emptied.
	assign exec = busy_q & (~rsp_valid_q | ~rsp_stall);

	assign full   = (count_q == CW'(DEPTH));
	assign enq_ok = exec & (func_q == FUNC_ENQUEUE) & ~full;

	// Cells compare against the incoming value on the accept edge; the match
	// flags stay stable while the request waits, since the queue does not change.
	assign ctl.cmp   = accept;
	assign ctl.shift = exec & (func_q == FUNC_REMOVE);

	assign seen[0] = 1'b0;
	assign found   = seen[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] newer;
		logic                 occ;
		logic                 ld;

		if (i == DEPTH - 1) begin : g_last
			assign newer = cell_word[i];
		end else begin : g_mid
			assign newer = cell_word[i+1];
		end

		assign occ = (CW'(i) < count_q);
		assign ld  = enq_ok & (count_q == CW'(i));

		cqdv_cell #(
			.WORD_BITS(WORD_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.cmp_word  (word_in),
			.load      (ld),
			.load_word (word_q),
			.occupied  (occ),
			.newer_word(newer),
			.seen_in   (seen[i]),
			.seen_out  (seen[i+1]),
			.word      (cell_word[i])
		);
	end

	// Request registers hold the operation and word until execution.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			word_q <= word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end

			if (exec) begin
				rsp_valid_q <= 1'b1;
				if (enq_ok) begin
					count_q <= count_q + CW'(1);
				end else if (ctl.shift && found) begin
					count_q <= count_q - CW'(1);
				end
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload: status and the occupancy after the operation.
	always_ff @(posedge clk) begin
		if (exec) begin
			if (func_q == FUNC_ENQUEUE) begin
				if (full) begin
					rsp_q.status    <= ST_FULL;
					rsp_q.occupancy <= 9'(count_q);
				end else begin
					rsp_q.status    <= ST_DONE;
					rsp_q.occupancy <= 9'(count_q + CW'(1));
				end
			end else begin
				if (found) begin
					rsp_q.status    <= ST_DONE;
					rsp_q.occupancy <= 9'(count_q - CW'(1));
				end else begin
					rsp_q.status    <= ST_NOT_FOUND;
					rsp_q.occupancy <= 9'(count_q);
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

@@ rtl/core/cqdv_checker.sv @@
// Port-level checker for the circular queue with remove-by-value, bound to the top level.
// Depends on cqdv_pkg for the request and response structs and status codes.
`default_nettype none

module cqdv_port_checker
	import cqdv_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// One request at a time: after acceptance the input stalls.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while previous request still executing");

	// A held response keeps its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed or vanished");

	// A full drop reports the queue at capacity.
	a_full_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.occupancy == 9'(DEPTH))
		else $error("full status with occupancy below capacity");

	// Only defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == ST_DONE || rsp.status == ST_FULL
			|| rsp.status == ST_NOT_FOUND)
		else $error("undefined status code");

endmodule

bind circular_queue_delete_by_value cqdv_port_checker #(
	.DEPTH(DEPTH)
) u_cqdv_port_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

`default_nettype wire
